// ===== rtl/mnrt_pkg.sv =====
// ----------------------------------------------------------------------------
// mnrt_pkg
// Shared types and constants of the mesh neighbour and route table: entry
// layout, configuration set, operation and register codes, reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package mnrt_pkg;

   // default table depth
   localparam int unsigned ENTRIES_DEF = 16;

   // weight added when a neighbour is heard
   localparam logic [7:0] HEARD_STEP = 8'd10;

   // configuration reset values
   localparam logic [7:0] SELF_ADDRESS_RST = 8'd0;
   localparam logic [7:0] WEIGHT_CAP_RST   = 8'd100;
   localparam logic [7:0] TRUST_WEIGHT_RST = 8'd30;
   localparam logic [7:0] HOP_CAP_RST      = 8'd8;

   // operation codes of a request
   typedef enum logic [2:0] {
      OP_HEARD  = 3'd0,
      OP_TICK   = 3'd1,
      OP_LOOKUP = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_MERGE  = 3'd4
   } op_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_SELF_ADDRESS = 2'd0,
      CSR_WEIGHT_CAP   = 2'd1,
      CSR_TRUST_WEIGHT = 2'd2,
      CSR_HOP_CAP      = 2'd3
   } csr_index_type;

   // one table entry as held in the memory
   typedef struct packed {
      logic [7:0] id;
      logic [7:0] weight;
      logic       trusted;
      logic [7:0] owner;
      logic [7:0] hops;
   } entry_type;

   // configuration set seen by the sequencer
   typedef struct packed {
      logic [7:0] self_address;
      logic [7:0] weight_cap;
      logic [7:0] trust_weight;
      logic [7:0] hop_cap;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/mesh_neighbor_route_table.sv =====
// ----------------------------------------------------------------------------
// mesh_neighbor_route_table
// Neighbour and route table of a mesh node: heard, tick, route lookup,
// clear owner and merge of one remote pair, one response per request.
// ----------------------------------------------------------------------------
// The table lives in a single-port-read memory that is walked one entry at a
// time (read issue, then evaluate): heard, lookup and merge walk once and
// then write, clear owner walks once, and tick walks once plus a second walk
// for every direct neighbour whose aged weight is non-zero and at or below
// the threshold, since its child routes are freed by that second walk. An
// unknown op or a merge pair that is ignored skips the walk and goes straight
// to the response. The next request is taken as soon as the response sits in
// the output register. The user must write the configuration registers only
// while no request is in progress; the block itself does not enforce this.
`default_nettype none

module mesh_neighbor_route_table #(
   parameter int unsigned ENTRIES = mnrt_pkg::ENTRIES_DEF
) (
   input  wire        clock,
   input  wire        reset,
   // configuration
   input  wire        csr_wr_en,
   input  wire [1:0]  csr_index,
   input  wire [7:0]  csr_wdata,
   // request channel
   input  wire        req_valid,
   output logic       req_stall,
   input  wire [2:0]  req_op,
   input  wire [7:0]  req_node_id,
   input  wire [7:0]  req_owner_id,
   input  wire [7:0]  req_hop_count,
   // response channel
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic       rsp_trusted,
   output logic       rsp_found,
   output logic [7:0] rsp_next_hop,
   output logic       rsp_table_full
);
   import mnrt_pkg::*;

   localparam int unsigned IDX_W = $clog2(ENTRIES);

   cfg_type          cfg_ff;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   entry_type        mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   entry_type        mem_rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.self_address <= SELF_ADDRESS_RST;
         cfg_ff.weight_cap   <= WEIGHT_CAP_RST;
         cfg_ff.trust_weight <= TRUST_WEIGHT_RST;
         cfg_ff.hop_cap      <= HOP_CAP_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SELF_ADDRESS: cfg_ff.self_address <= csr_wdata;
            CSR_WEIGHT_CAP:   cfg_ff.weight_cap   <= csr_wdata;
            CSR_TRUST_WEIGHT: cfg_ff.trust_weight <= csr_wdata;
            CSR_HOP_CAP:      cfg_ff.hop_cap      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // sequencer
   mnrt_ctrl #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_node_id    (req_node_id),
      .req_owner_id   (req_owner_id),
      .req_hop_count  (req_hop_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_trusted    (rsp_trusted),
      .rsp_found      (rsp_found),
      .rsp_next_hop   (rsp_next_hop),
      .rsp_table_full (rsp_table_full),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   // entry memory
   mnrt_table_mem #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

// ===== rtl/mnrt_table_mem.sv =====
// ----------------------------------------------------------------------------
// mnrt_table_mem
// Entry memory of the route table: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mnrt_table_mem #(
   parameter int unsigned ENTRIES = 16,
   parameter int unsigned IDX_W   = $clog2(ENTRIES)
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [IDX_W-1:0]         wr_addr,
   input  mnrt_pkg::entry_type     wr_data,
   input  wire                     rd_en,
   input  wire [IDX_W-1:0]         rd_addr,
   output mnrt_pkg::entry_type     rd_data
);
   import mnrt_pkg::*;

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/mnrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// mnrt_ctrl
// Sequencer of the route table: walks the entry memory one entry at a time,
// keeps the in-use flags, applies the update and holds the response.
// ----------------------------------------------------------------------------
`default_nettype none

module mnrt_ctrl #(
   parameter int unsigned ENTRIES = 16,
   parameter int unsigned IDX_W   = $clog2(ENTRIES)
) (
   input  wire                     clock,
   input  wire                     reset,
   input  mnrt_pkg::cfg_type       cfg,
   // request channel
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire [2:0]               req_op,
   input  wire [7:0]               req_node_id,
   input  wire [7:0]               req_owner_id,
   input  wire [7:0]               req_hop_count,
   // response channel
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic                    rsp_trusted,
   output logic                    rsp_found,
   output logic [7:0]              rsp_next_hop,
   output logic                    rsp_table_full,
   // entry memory
   output logic                    mem_wr_en,
   output logic [IDX_W-1:0]        mem_wr_addr,
   output mnrt_pkg::entry_type     mem_wr_data,
   output logic                    mem_rd_en,
   output logic [IDX_W-1:0]        mem_rd_addr,
   input  mnrt_pkg::entry_type     mem_rd_data
);
   import mnrt_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_RD   = 7'b0000010,
      S_EV   = 7'b0000100,
      S_CRD  = 7'b0001000,
      S_CEV  = 7'b0010000,
      S_WR   = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [ENTRIES-1:0] used_ff, used_in;
   logic [2:0]       op_ff, op_in;
   logic [7:0]       node_ff, node_in;
   logic [7:0]       owner_ff, owner_in;
   logic [7:0]       hop_ff, hop_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] cidx_ff, cidx_in;
   logic [7:0]       key_ff, key_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   entry_type        hit_ent_ff, hit_ent_in;
   logic             free_ok_ff, free_ok_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             res_trusted_ff, res_trusted_in;
   logic             res_found_ff, res_found_in;
   logic [7:0]       res_next_ff, res_next_in;
   logic             res_full_ff, res_full_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_trusted_ff, rsp_trusted_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [7:0]       rsp_next_hop_ff, rsp_next_hop_in;
   logic             rsp_table_full_ff, rsp_table_full_in;

   logic             merge_skip;
   logic [7:0]       weight_dec;
   logic [8:0]       heard_sum;
   logic [7:0]       heard_weight;
   logic [7:0]       insert_weight;
   logic [8:0]       hop_next;
   logic             merge_take;
   entry_type        new_ent;

   // merge pairs that never touch the table
   assign merge_skip = (req_node_id == 8'd0) || (req_node_id == cfg.self_address) ||
                       (req_hop_count >= cfg.hop_cap);

   // weight arithmetic
   assign weight_dec    = (mem_rd_data.weight != 8'd0) ? mem_rd_data.weight - 8'd1 : 8'd0;
   assign heard_sum     = {1'b0, hit_ent_ff.weight} + {1'b0, HEARD_STEP};
   assign heard_weight  = (heard_sum > {1'b0, cfg.weight_cap}) ? cfg.weight_cap
                                                              : heard_sum[7:0];
   assign insert_weight = (HEARD_STEP > cfg.weight_cap) ? cfg.weight_cap : HEARD_STEP;
   assign hop_next      = {1'b0, hop_ff} + 9'd1;
   assign merge_take    = ({1'b0, hit_ent_ff.hops} > hop_next) || !hit_ent_ff.trusted;

   // sequencer; each memory read is issued in one state and used in the next,
   // so a write-back always lands before any later read of the same entry
   always_comb begin
      state_in          = state_ff;
      used_in           = used_ff;
      op_in             = op_ff;
      node_in           = node_ff;
      owner_in          = owner_ff;
      hop_in            = hop_ff;
      idx_in            = idx_ff;
      cidx_in           = cidx_ff;
      key_in            = key_ff;
      hit_in            = hit_ff;
      hit_idx_in        = hit_idx_ff;
      hit_ent_in        = hit_ent_ff;
      free_ok_in        = free_ok_ff;
      free_idx_in       = free_idx_ff;
      res_trusted_in    = res_trusted_ff;
      res_found_in      = res_found_ff;
      res_next_in       = res_next_ff;
      res_full_in       = res_full_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_trusted_in    = rsp_trusted_ff;
      rsp_found_in      = rsp_found_ff;
      rsp_next_hop_in   = rsp_next_hop_ff;
      rsp_table_full_in = rsp_table_full_ff;
      mem_rd_en         = 1'b0;
      mem_rd_addr       = idx_ff;
      mem_wr_en         = 1'b0;
      mem_wr_addr       = idx_ff;
      mem_wr_data       = mem_rd_data;
      new_ent           = mem_rd_data;

      unique case (state_ff)
         // take a new request
         S_IDLE: begin
            if (req_valid) begin
               op_in          = req_op;
               node_in        = req_node_id;
               owner_in       = req_owner_id;
               hop_in         = req_hop_count;
               idx_in         = '0;
               cidx_in        = '0;
               key_in         = req_owner_id;
               hit_in         = 1'b0;
               free_ok_in     = 1'b0;
               res_trusted_in = 1'b0;
               res_found_in   = 1'b0;
               res_next_in    = 8'd0;
               res_full_in    = 1'b0;
               case (req_op) inside
                  OP_HEARD, OP_TICK, OP_LOOKUP: state_in = S_RD;
                  OP_CLEAR: state_in = S_CRD;
                  OP_MERGE: state_in = merge_skip ? S_DONE : S_RD;
                  default:  state_in = S_DONE;
               endcase
            end
         end

         // main walk: issue read
         S_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx_ff;
            state_in    = S_EV;
         end

         // main walk: evaluate the entry
         S_EV: begin
            if (op_ff == OP_TICK) begin
               // age the weight and settle a direct neighbour
               mem_wr_en          = used_ff[idx_ff];
               mem_wr_addr        = idx_ff;
               mem_wr_data        = mem_rd_data;
               mem_wr_data.weight = weight_dec;
               if (used_ff[idx_ff] && (mem_rd_data.owner == 8'd0)) begin
                  if (weight_dec == 8'd0) begin
                     used_in[idx_ff] = 1'b0;
                  end else if (weight_dec > cfg.trust_weight) begin
                     mem_wr_data.trusted = 1'b1;
                  end else begin
                     mem_wr_data.trusted = 1'b0;
                     key_in  = mem_rd_data.id;
                     cidx_in = '0;
                  end
               end
               if (used_ff[idx_ff] && (mem_rd_data.owner == 8'd0) &&
                   (weight_dec != 8'd0) && !(weight_dec > cfg.trust_weight)) begin
                  state_in = S_CRD;
               end else if (idx_ff == LAST_IDX) begin
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_RD;
               end
            end else begin
               // first matching in-use entry and first free slot
               if (used_ff[idx_ff] && (mem_rd_data.id == node_ff) && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = idx_ff;
                  hit_ent_in = mem_rd_data;
               end
               if (!used_ff[idx_ff] && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = idx_ff;
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = S_WR;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_RD;
               end
            end
         end

         // owner walk: issue read
         S_CRD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = cidx_ff;
            state_in    = S_CEV;
         end

         // owner walk: free entries of this owner
         S_CEV: begin
            if (used_ff[cidx_ff] && (mem_rd_data.owner == key_ff)) begin
               used_in[cidx_ff] = 1'b0;
            end
            if (cidx_ff != LAST_IDX) begin
               cidx_in  = cidx_ff + IDX_W'(1);
               state_in = S_CRD;
            end else if ((op_ff == OP_TICK) && (idx_ff != LAST_IDX)) begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_RD;
            end else begin
               state_in = S_DONE;
            end
         end

         // apply the update found by the walk
         S_WR: begin
            state_in = S_DONE;
            case (op_ff)
               OP_HEARD: begin
                  if (hit_ff) begin
                     new_ent        = hit_ent_ff;
                     new_ent.weight = heard_weight;
                     new_ent.owner  = 8'd0;
                     new_ent.hops   = 8'd1;
                     mem_wr_en      = 1'b1;
                     mem_wr_addr    = hit_idx_ff;
                     mem_wr_data    = new_ent;
                     res_trusted_in = hit_ent_ff.trusted;
                  end else if (free_ok_ff) begin
                     new_ent.id      = node_ff;
                     new_ent.weight  = insert_weight;
                     new_ent.trusted = 1'b0;
                     new_ent.owner   = 8'd0;
                     new_ent.hops    = 8'd1;
                     mem_wr_en       = 1'b1;
                     mem_wr_addr     = free_idx_ff;
                     mem_wr_data     = new_ent;
                     used_in[free_idx_ff] = 1'b1;
                  end else begin
                     res_full_in = 1'b1;
                  end
               end
               OP_MERGE: begin
                  if (hit_ff) begin
                     new_ent       = hit_ent_ff;
                     new_ent.owner = owner_ff;
                     new_ent.hops  = hop_next[7:0];
                     mem_wr_en     = merge_take;
                     mem_wr_addr   = hit_idx_ff;
                     mem_wr_data   = new_ent;
                  end else if (free_ok_ff) begin
                     new_ent.id      = node_ff;
                     new_ent.weight  = 8'd0;
                     new_ent.trusted = 1'b1;
                     new_ent.owner   = owner_ff;
                     new_ent.hops    = hop_next[7:0];
                     mem_wr_en       = 1'b1;
                     mem_wr_addr     = free_idx_ff;
                     mem_wr_data     = new_ent;
                     used_in[free_idx_ff] = 1'b1;
                  end else begin
                     res_full_in = 1'b1;
                  end
               end
               OP_LOOKUP: begin
                  res_found_in = hit_ff;
                  if (hit_ff) begin
                     res_next_in = (hit_ent_ff.owner != 8'd0) ? hit_ent_ff.owner : node_ff;
                  end
               end
               default: begin
               end
            endcase
         end

         // hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_trusted_in    = res_trusted_ff;
               rsp_found_in      = res_found_ff;
               rsp_next_hop_in   = res_next_ff;
               rsp_table_full_in = res_full_ff;
               state_in          = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff             <= op_in;
      node_ff           <= node_in;
      owner_ff          <= owner_in;
      hop_ff            <= hop_in;
      idx_ff            <= idx_in;
      cidx_ff           <= cidx_in;
      key_ff            <= key_in;
      hit_ff            <= hit_in;
      hit_idx_ff        <= hit_idx_in;
      hit_ent_ff        <= hit_ent_in;
      free_ok_ff        <= free_ok_in;
      free_idx_ff       <= free_idx_in;
      res_trusted_ff    <= res_trusted_in;
      res_found_ff      <= res_found_in;
      res_next_ff       <= res_next_in;
      res_full_ff       <= res_full_in;
      rsp_trusted_ff    <= rsp_trusted_in;
      rsp_found_ff      <= rsp_found_in;
      rsp_next_hop_ff   <= rsp_next_hop_in;
      rsp_table_full_ff <= rsp_table_full_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_trusted    = rsp_trusted_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_next_hop   = rsp_next_hop_ff;
   assign rsp_table_full = rsp_table_full_ff;

endmodule

`default_nettype wire

// ===== rtl/mnrt_checker.sv =====
// ----------------------------------------------------------------------------
// mnrt_checker
// Port-level checks of the route table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mnrt_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_stall,
   input wire       rsp_valid,
   input wire       rsp_stall,
   input wire       rsp_trusted,
   input wire       rsp_found,
   input wire [7:0] rsp_next_hop,
   input wire       rsp_table_full
);

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_next_hop) &&
         $stable(rsp_found) && $stable(rsp_trusted) && $stable(rsp_table_full))
      else $error("stalled response changed");

   // lookup fields and heard/merge fields never appear together
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && (rsp_trusted || rsp_table_full)))
      else $error("response mixes lookup and update fields");

   // next hop is only given with a found route
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_next_hop == 8'd0)
      else $error("next hop without a route");

   // a request never answers in the cycle after it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("response too early");

   // no response straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind mesh_neighbor_route_table mnrt_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_trusted    (rsp_trusted),
   .rsp_found      (rsp_found),
   .rsp_next_hop   (rsp_next_hop),
   .rsp_table_full (rsp_table_full)
);

`default_nettype wire

// ===== verif/route_table_sb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_table_sb_pkg
// Expected-behaviour tracker for the mesh neighbour and route table. It keeps
// its own copy of the table and of the settings, works out the response of
// every request as it is taken, and checks responses in arrival order.
// ----------------------------------------------------------------------------

package route_table_sb_pkg;

   import mnrt_pkg::*;

   // one response as seen on the output channel
   typedef struct packed {
      logic       trusted;
      logic       found;
      logic [7:0] next_hop;
      logic       table_full;
   } route_answer_type;

   class route_table_scoreboard;

      // settings mirror
      logic [7:0] self_addr;
      logic [7:0] wt_ceiling;
      logic [7:0] trust_level;
      logic [7:0] hop_limit;

      // table mirror
      bit         live  [ENTRIES_DEF];
      logic [7:0] node  [ENTRIES_DEF];
      logic [7:0] wt    [ENTRIES_DEF];
      bit         trust [ENTRIES_DEF];
      logic [7:0] via   [ENTRIES_DEF];
      logic [7:0] hop_cnt [ENTRIES_DEF];

      route_answer_type due_answers [$];
      int               failures;
      int               answers_seen;

      function new();
         self_addr   = SELF_ADDRESS_RST;
         wt_ceiling  = WEIGHT_CAP_RST;
         trust_level = TRUST_WEIGHT_RST;
         hop_limit   = HOP_CAP_RST;
         foreach (live[i]) begin
            live[i]    = 1'b0;
            node[i]    = '0;
            wt[i]      = '0;
            trust[i]   = 1'b0;
            via[i]     = '0;
            hop_cnt[i] = '0;
         end
         failures     = 0;
         answers_seen = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [7:0] value);
         case (idx)
            CSR_SELF_ADDRESS: self_addr   = value;
            CSR_WEIGHT_CAP:   wt_ceiling  = value;
            CSR_TRUST_WEIGHT: trust_level = value;
            CSR_HOP_CAP:      hop_limit   = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return due_answers.size();
      endfunction

      // lowest in-use slot holding this id
      function int first_live(logic [7:0] id);
         for (int i = 0; i < ENTRIES_DEF; i++)
            if (live[i] && node[i] == id) return i;
         return -1;
      endfunction

      function int first_free();
         for (int i = 0; i < ENTRIES_DEF; i++)
            if (!live[i]) return i;
         return -1;
      endfunction

      // release every route reached through this neighbour
      function void drop_routes_via(logic [7:0] hop);
         for (int j = 0; j < ENTRIES_DEF; j++)
            if (live[j] && via[j] == hop) live[j] = 1'b0;
      endfunction

      // apply one accepted request and queue the response it must give
      function void note_request(logic [2:0] op, logic [7:0] node_id,
                                 logic [7:0] owner_id, logic [7:0] hop_count);
         route_answer_type ans;
         int k;
         int sum;
         ans = '0;
         case (op)
            OP_HEARD: begin
               k = first_live(node_id);
               if (k >= 0) begin
                  sum = int'(wt[k]) + int'(HEARD_STEP);
                  wt[k]      = (sum > int'(wt_ceiling)) ? wt_ceiling : sum[7:0];
                  via[k]     = '0;
                  hop_cnt[k] = 8'd1;
               end else begin
                  k = first_free();
                  if (k >= 0) begin
                     live[k]    = 1'b1;
                     node[k]    = node_id;
                     wt[k]      = (HEARD_STEP > wt_ceiling) ? wt_ceiling : HEARD_STEP;
                     trust[k]   = 1'b0;
                     via[k]     = '0;
                     hop_cnt[k] = 8'd1;
                  end else begin
                     ans.table_full = 1'b1;
                  end
               end
               k = first_live(node_id);
               if (k >= 0) ans.trusted = trust[k];
            end
            OP_TICK: begin
               // ageing walk, in slot order, children freed as it goes
               for (int i = 0; i < ENTRIES_DEF; i++) begin
                  if (wt[i] != 0) wt[i] = wt[i] - 8'd1;
                  if (live[i] && via[i] == 0) begin
                     if (wt[i] == 0) begin
                        live[i] = 1'b0;
                     end else if (wt[i] > trust_level) begin
                        trust[i] = 1'b1;
                     end else begin
                        trust[i] = 1'b0;
                        drop_routes_via(node[i]);
                     end
                  end
               end
            end
            OP_LOOKUP: begin
               k = first_live(node_id);
               if (k >= 0) begin
                  ans.found    = 1'b1;
                  ans.next_hop = (via[k] != 0) ? via[k] : node_id;
               end
            end
            OP_CLEAR: begin
               drop_routes_via(owner_id);
            end
            OP_MERGE: begin
               if (node_id != 0 && node_id != self_addr && hop_count < hop_limit) begin
                  k = first_live(node_id);
                  if (k >= 0) begin
                     if (int'(hop_cnt[k]) > int'(hop_count) + 1 || !trust[k]) begin
                        via[k]     = owner_id;
                        hop_cnt[k] = hop_count + 8'd1;
                     end
                  end else begin
                     k = first_free();
                     if (k >= 0) begin
                        live[k]    = 1'b1;
                        node[k]    = node_id;
                        wt[k]      = '0;
                        trust[k]   = 1'b1;
                        via[k]     = owner_id;
                        hop_cnt[k] = hop_count + 8'd1;
                     end else begin
                        ans.table_full = 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
         due_answers.push_back(ans);
      endfunction

      // compare one response with the oldest one owed
      function void check_response(route_answer_type got);
         route_answer_type want;
         answers_seen++;
         if (due_answers.size() == 0) begin
            if (failures < 10)
               $display("response %0d arrived with none outstanding", answers_seen);
            failures++;
            return;
         end
         want = due_answers.pop_front();
         if (got.trusted !== want.trusted || got.found !== want.found ||
             got.next_hop !== want.next_hop || got.table_full !== want.table_full) begin
            if (failures < 10) begin
               $display("response %0d: expected trusted=%0b found=%0b next_hop=%02h table_full=%0b",
                        answers_seen, want.trusted, want.found, want.next_hop,
                        want.table_full);
               $display("response %0d: got trusted=%0b found=%0b next_hop=%02h table_full=%0b",
                        answers_seen, got.trusted, got.found, got.next_hop,
                        got.table_full);
            end
            failures++;
         end
      endfunction

   endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the mesh neighbour and route table. A directed opening covers
// the corner cases, then random traffic around a small id pool runs under
// several settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module tb_top;

   import mnrt_pkg::*;
   import route_table_sb_pkg::*;

   localparam int unsigned CLOCK_PERIOD  = 10;
   localparam int unsigned CYCLE_LIMIT   = 2_000_000;
   localparam int unsigned GAP_MAX       = 11;
   localparam int unsigned LONG_HOLD     = 400;
   localparam int unsigned LONG_HOLD_AT  = 150;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned ID_POOL       = 24;

   // codes the block does not implement
   localparam logic [2:0] OP_FIRST_UNKNOWN = 3'd5;
   localparam logic [2:0] OP_LAST_UNKNOWN  = 3'd7;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       csr_wr_en      = 1'b0;
   logic [1:0] csr_index      = '0;
   logic [7:0] csr_wdata      = '0;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [2:0] req_op         = '0;
   logic [7:0] req_node_id    = '0;
   logic [7:0] req_owner_id   = '0;
   logic [7:0] req_hop_count  = '0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic       rsp_trusted;
   logic       rsp_found;
   logic [7:0] rsp_next_hop;
   logic       rsp_table_full;

   route_table_scoreboard sb;
   int cycles   = 0;
   int send_run = 0;

   mesh_neighbor_route_table uut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_node_id    (req_node_id),
      .req_owner_id   (req_owner_id),
      .req_hop_count  (req_hop_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_trusted    (rsp_trusted),
      .rsp_found      (rsp_found),
      .rsp_next_hop   (rsp_next_hop),
      .rsp_table_full (rsp_table_full)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // idle length per request, with occasional runs of back-to-back traffic
   function automatic int draw_gap(inout int run);
      if (run > 0) begin
         run--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         run = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, GAP_MAX);
   endfunction

   task automatic send_request(input logic [2:0] op, input logic [7:0] node_id,
                               input logic [7:0] owner_id, input logic [7:0] hop_count);
      int gap;
      gap = draw_gap(send_run);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_node_id   <= node_id;
      req_owner_id  <= owner_id;
      req_hop_count <= hop_count;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(op, node_id, owner_id, hop_count);
   endtask

   // hold the request side quiet until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_config(input logic [7:0] self_a, input logic [7:0] wmax,
                               input logic [7:0] thr, input logic [7:0] hops_lim);
      csr_index_type regs [4] = '{CSR_SELF_ADDRESS, CSR_WEIGHT_CAP,
                                  CSR_TRUST_WEIGHT, CSR_HOP_CAP};
      logic [7:0]    vals [4];
      vals = '{self_a, wmax, thr, hops_lim};
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.write_register(regs[i], vals[i]);
      end
      csr_wr_en <= 1'b0;
   endtask

   // random traffic: ids mostly from a small pool so entries get reused
   task automatic run_random(input int count);
      int         pick;
      logic [2:0] op;
      logic [7:0] node_id;
      logic [7:0] owner_id;
      logic [7:0] hop_count;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 34)      op = OP_HEARD;
         else if (pick < 46) op = OP_TICK;
         else if (pick < 66) op = OP_LOOKUP;
         else if (pick < 73) op = OP_CLEAR;
         else if (pick < 97) op = OP_MERGE;
         else                op = OP_FIRST_UNKNOWN + 3'($urandom_range(0, 2));
         node_id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, ID_POOL));
         pick = $urandom_range(0, 9);
         if (op != OP_CLEAR && op != OP_MERGE) owner_id = 8'($urandom_range(0, 255));
         else if (pick == 0)                   owner_id = '0;
         else if (pick == 1)                   owner_id = 8'($urandom_range(0, 255));
         else                                  owner_id = 8'($urandom_range(1, ID_POOL));
         hop_count = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 10));
         send_request(op, node_id, owner_id, hop_count);
      end
   endtask

   // response side: random stalls, one long hold-off to back the block up
   initial begin : response_side
      int               hold;
      int               run;
      int               seen;
      route_answer_type got;
      hold = 0;
      run  = 0;
      seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got.trusted    = rsp_trusted;
            got.found      = rsp_found;
            got.next_hop   = rsp_next_hop;
            got.table_full = rsp_table_full;
            sb.check_response(got);
            seen++;
            hold = (seen == LONG_HOLD_AT) ? LONG_HOLD : draw_gap(run);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed opening under the reset settings
      send_request(OP_FIRST_UNKNOWN, 8'hFF, 8'hFF, 8'hFF);
      send_request(OP_LAST_UNKNOWN, 8'h00, 8'h00, 8'h00);
      send_request(OP_LOOKUP, 8'hFF, 8'h00, 8'h00);
      repeat (4) send_request(OP_HEARD, 8'hFF, 8'h00, 8'h00);
      send_request(OP_TICK, 8'h00, 8'h00, 8'h00);
      send_request(OP_HEARD, 8'hFF, 8'h00, 8'h00);
      // merge pairs: id zero, too many hops, fresh insert, shorter route
      send_request(OP_MERGE, 8'h00, 8'hFF, 8'h01);
      send_request(OP_MERGE, 8'h09, 8'hFF, 8'h08);
      send_request(OP_MERGE, 8'h09, 8'hFF, 8'h02);
      send_request(OP_MERGE, 8'h09, 8'hAA, 8'h00);
      send_request(OP_LOOKUP, 8'h09, 8'h00, 8'h00);
      // merge from owner zero behaves as a direct neighbour
      send_request(OP_MERGE, 8'h0C, 8'h00, 8'h07);
      send_request(OP_LOOKUP, 8'h0C, 8'h00, 8'h00);
      // neighbour with id zero, then lookup of it
      send_request(OP_HEARD, 8'h00, 8'h00, 8'h00);
      send_request(OP_LOOKUP, 8'h00, 8'h00, 8'h00);
      send_request(OP_CLEAR, 8'h00, 8'hAA, 8'h00);
      send_request(OP_LOOKUP, 8'h09, 8'h00, 8'h00);
      send_request(OP_TICK, 8'h00, 8'h00, 8'h00);
      send_request(OP_CLEAR, 8'h00, 8'h00, 8'h00);
      send_request(OP_LOOKUP, 8'hFF, 8'h00, 8'h00);
      drain();

      // extreme settings, zero weight ceiling first
      write_config(8'hFF, 8'h00, 8'h00, 8'hFF);
      run_random(60);
      drain();
      write_config(8'h00, 8'hFF, 8'hFF, 8'h01);
      run_random(60);
      drain();

      // mid-range settings, self address always inside the id pool
      repeat (4) begin
         write_config(8'($urandom_range(0, ID_POOL)), 8'($urandom_range(1, 255)),
                      8'($urandom_range(0, 60)), 8'($urandom_range(1, 16)));
         run_random(120);
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
